// ===== hw/rtl/binary_image_run_length_encoder_unit_assert.svh =====
// assertion macros for the run length encoder
`ifndef BINARY_IMAGE_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`define BINARY_IMAGE_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BIRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BIRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/birle_pkg.sv =====
// shared types and constants of the run length encoder
package birle_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int NUM_W       = IDX_W + 1;

    localparam logic [6:0] RUN_CAP    = 7'd100;
    localparam logic [6:0] RUN_START  = 7'd1;
    localparam logic [7:0] RUN_SPLIT  = 8'd99;
    localparam logic [7:0] RUN_ZERO   = 8'd0;
    localparam logic [7:0] HDR_A      = 8'h7A;
    localparam logic [7:0] HDR_B      = 8'h21;

    localparam logic [7:0] THRESHOLD_RST = 8'd100;
    localparam logic [7:0] WIDTH_RST     = 8'd160;
    localparam logic [7:0] HEIGHT_RST    = 8'd120;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] frame_width;
        logic [7:0] frame_height;
    } t_cfg;

endpackage

// ===== hw/rtl/birle_regs.sv =====
// configuration registers behind the apb port
module birle_regs
    import birle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= THRESHOLD_RST;
            r_cfg.frame_width  <= WIDTH_RST;
            r_cfg.frame_height <= HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: r_cfg.threshold    <= pwdata[7:0];
                REG_WIDTH:     r_cfg.frame_width  <= pwdata[7:0];
                REG_HEIGHT:    r_cfg.frame_height <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_THRESHOLD: prdata = {24'd0, r_cfg.threshold};
            REG_WIDTH:     prdata = {24'd0, r_cfg.frame_width};
            REG_HEIGHT:    prdata = {24'd0, r_cfg.frame_height};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/binary_image_run_length_encoder_unit.sv =====
// top level of the thresholded run length encoder
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: pixel, tuser: frame_start
// m_axis    out  tvalid/tready          tdata: out_byte, tlast: last
// apb       in   psel/penable, pready   threshold, frame_width, frame_height
//
// one item is taken per cycle when it causes at most one result byte and m_axis_tready stays high
// an item causing n bytes holds the result register until all n are taken (header 6 or 7, cap 2)
// items are classed and planned in one step from the input register
// the input register takes a new item while results still wait on m_axis
// reset is synchronous, clears the valids and returns run state and the config registers to their reset values
`include "binary_image_run_length_encoder_unit_assert.svh"

module binary_image_run_length_encoder_unit
    import birle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    birle_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic             r_in_v;
    logic [7:0]       r_pixel;
    logic             r_start;
    logic [6:0]       r_cnt;
    logic             r_prev;
    logic             r_em_v;
    logic [IDX_W-1:0] r_idx;
    logic [NUM_W-1:0] r_n;
    logic [7:0]       r_bytes [MAX_RESULTS];

    logic [6:0]       n_cnt;
    logic [6:0]       w_cnt0;
    logic [6:0]       w_cnt1;
    logic             w_prev0;
    logic             w_white;
    logic             w_same;
    logic             w_cap;
    logic             w_load;
    logic             w_last;
    logic [NUM_W-1:0] n_n;
    logic [7:0]       n_bytes [MAX_RESULTS];

    assign w_last        = ({1'b0, r_idx} == (r_n - NUM_W'(1)));
    assign w_load        = r_in_v && (!r_em_v || (m_axis_tready && w_last));
    assign s_axis_tready = !r_in_v || w_load;
    assign m_axis_tvalid = r_em_v;
    assign m_axis_tdata  = r_bytes[r_idx];
    assign m_axis_tlast  = w_last;

    // run state after a possible frame restart
    assign w_cnt0  = r_start ? RUN_START : r_cnt;
    assign w_prev0 = r_start ? 1'b1 : r_prev;
    assign w_white = r_pixel > w_cfg.threshold;
    assign w_same  = (w_white == w_prev0);
    assign w_cnt1  = w_same ? (w_cnt0 + 7'd1) : RUN_START;
    assign w_cap   = (w_cnt1 == RUN_CAP);
    assign n_cnt   = w_cap ? RUN_START : w_cnt1;

    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_bytes[k] = RUN_ZERO;
        end
        n_n = '0;
        if (r_start) begin
            n_bytes[0] = HDR_A;
            n_bytes[1] = HDR_B;
            n_bytes[2] = w_cfg.frame_width;
            n_bytes[3] = w_cfg.frame_height;
            n_bytes[4] = HDR_A;
            n_bytes[5] = HDR_B;
            n_n        = NUM_W'(6);
        end
        if (!w_same) begin
            n_bytes[n_n[IDX_W-1:0]] = {1'b0, w_cnt0};
            n_n = n_n + NUM_W'(1);
        end
        if (w_cap) begin
            n_bytes[n_n[IDX_W-1:0]]              = RUN_SPLIT;
            n_bytes[n_n[IDX_W-1:0] + IDX_W'(1)]  = RUN_ZERO;
            n_n = n_n + NUM_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pixel <= s_axis_tdata;
            r_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= RUN_START;
            r_prev <= 1'b1;
            r_em_v <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_cnt  <= n_cnt;
            r_prev <= w_white;
            r_em_v <= (n_n != '0);
            r_idx  <= '0;
        end else if (r_em_v && m_axis_tready) begin
            if (w_last) begin
                r_em_v <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_n     <= n_n;
            r_bytes <= n_bytes;
        end
    end

    `BIRLE_ASSERT_IMPL(a_cnt_range, 1'b1,
        (r_cnt >= RUN_START) && (r_cnt < RUN_CAP), "run count out of range")
    `BIRLE_ASSERT_IMPL(a_idx_bound, r_em_v,
        ({1'b0, r_idx} < r_n), "result index past byte count")
    `BIRLE_ASSERT_NEXT(a_last_frees, r_em_v && m_axis_tready && w_last && !w_load,
        !r_em_v, "result register not freed after last")

endmodule

// ===== bench/birle_stream_checker.sv =====
// checker for the run length encoder: follows the pixel and config ports, predicts and compares
module birle_stream_checker
    import birle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [7:0]  i_pix,          // pixel[7:0]
    input  logic        i_sof,          // frame_start
    input  logic        i_enc_valid,
    input  logic        i_enc_ready,
    input  logic [7:0]  i_enc_byte,     // out_byte[7:0]
    input  logic        i_enc_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_enc_item;

    t_enc_item  pending_codes [$];
    logic [7:0] cfg_threshold;
    logic [7:0] cfg_width;
    logic [7:0] cfg_height;
    logic [6:0] run_len;
    logic       prev_white;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic flag_mismatch(input string msg);
        if (o_mismatches < 10) begin
            $display("%s", msg);
        end
        o_mismatches++;
    endtask

    // bytes caused by one pixel, the final one carrying last
    task automatic predict_encoding(input logic [7:0] pix, input logic sof);
        logic [7:0] burst [$];
        logic       is_white;
        t_enc_item  entry;
        burst = {};
        if (sof) begin
            burst.push_back(HDR_A);
            burst.push_back(HDR_B);
            burst.push_back(cfg_width);
            burst.push_back(cfg_height);
            burst.push_back(HDR_A);
            burst.push_back(HDR_B);
            run_len    = RUN_START;
            prev_white = 1'b1;
        end
        is_white = pix > cfg_threshold;
        if (is_white == prev_white) begin
            run_len = run_len + 7'd1;
        end else begin
            burst.push_back({1'b0, run_len});
            run_len = RUN_START;
        end
        if (run_len == RUN_CAP) begin
            burst.push_back(RUN_SPLIT);
            burst.push_back(RUN_ZERO);
            run_len = RUN_START;
        end
        prev_white = is_white;
        foreach (burst[i]) begin
            entry.code = burst[i];
            entry.last = (i == burst.size() - 1);
            pending_codes.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin
        t_enc_item want;
        if (!i_rst_n) begin
            cfg_threshold = THRESHOLD_RST;
            cfg_width     = WIDTH_RST;
            cfg_height    = HEIGHT_RST;
            run_len       = RUN_START;
            prev_white    = 1'b1;
            pending_codes.delete();
        end else begin
            // results first, so a byte never meets an expectation queued at the same edge
            if (i_enc_valid && i_enc_ready) begin
                o_checked++;
                if (pending_codes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                            i_enc_byte, i_enc_last));
                end else begin
                    want = pending_codes.pop_front();
                    if (want.code !== i_enc_byte || want.last !== i_enc_last) begin
                        flag_mismatch($sformatf(
                            "byte %0d: expected %02h last %0b, got %02h last %0b",
                            o_checked, want.code, want.last, i_enc_byte, i_enc_last));
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_encoding(i_pix, i_sof);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_THRESHOLD: cfg_threshold = i_pwdata[7:0];
                    REG_WIDTH:     cfg_width     = i_pwdata[7:0];
                    REG_HEIGHT:    cfg_height    = i_pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_codes.size();
    end

endmodule

// ===== bench/binary_image_run_length_encoder_unit_tb.sv =====
// testbench top: pixel stream and register writes for the run length encoder, with verdict
module binary_image_run_length_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import birle_pkg::*;

    localparam int         PHASE_ITEMS  = 40;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [3:0] ADDR_UNUSED  = 4'd12;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // pixel[7:0]
    logic        s_axis_tuser;      // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;      // out_byte[7:0]
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    int   checked;
    int   cycles;
    int   items_sent;
    int   frames_sent;
    int   stall_left;
    bit   idle_allowed;
    bit   idle_on;
    logic [7:0] cur_thr;

    binary_image_run_length_encoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    birle_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix        (s_axis_tdata),
        .i_sof        (s_axis_tuser),
        .i_enc_valid  (m_axis_tvalid),
        .i_enc_ready  (m_axis_tready),
        .i_enc_byte   (m_axis_tdata),
        .i_enc_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("binary_image_run_length_encoder_unit verification failed");
            $finish;
        end
    end

    // output back-pressure in bursts
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (sof) begin
            frames_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic bus_write(input logic [3:0] addr, input logic [7:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {24'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] w, input logic [7:0] h);
        wait_idle();
        bus_write({REG_THRESHOLD, 2'b00}, thr);
        bus_write({REG_WIDTH, 2'b00}, w);
        bus_write({REG_HEIGHT, 2'b00}, h);
        cur_thr = thr;
    endtask

    // grey value on the wanted side of the threshold where one exists, often right at the edge
    function automatic logic [7:0] level_pixel(input bit white);
        if ($urandom_range(0, 5) == 0) begin
            return white ? cur_thr + 8'd1 : cur_thr;
        end else if (white && cur_thr != 8'hFF) begin
            return 8'($urandom_range(int'(cur_thr) + 1, 255));
        end else if (!white) begin
            return 8'($urandom_range(0, int'(cur_thr)));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // frames of alternating runs, mostly short, now and then past the cap, with some noise
    task automatic run_phase(input int budget, input bit long_first);
        int done;
        int left;
        int len;
        bit white;
        done = 0;
        while (done < budget) begin
            idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
            white   = 1'($urandom_range(0, 1));
            send_pixel(level_pixel(white), 1'b1);
            done++;
            left = $urandom_range(6, 40);
            while (left > 0) begin
                white = !white;
                if (long_first || $urandom_range(0, 79) == 0) begin
                    len = $urandom_range(95, 130);
                end else begin
                    len = $urandom_range(1, 6);
                end
                long_first = 1'b0;
                repeat (len) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    end else begin
                        send_pixel(level_pixel(white), 1'b0);
                    end
                end
                left -= len;
                done += len;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        frames_sent   = 0;
        idle_allowed  = 1'b1;
        idle_on       = 1'b1;
        cur_thr       = THRESHOLD_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pixels ahead of any frame start run on the reset state
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd0, 1'b0);
        // black first pixel, pixel equal to the threshold, white run
        send_pixel(8'd0, 1'b1);
        send_pixel(THRESHOLD_RST, 1'b0);
        send_pixel(THRESHOLD_RST + 8'd1, 1'b0);
        send_pixel(8'd255, 1'b0);
        // white first pixel, then a frame start right after a level change
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b1);
        // nothing can be white
        set_config(8'hFF, 8'h00, 8'h00);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        // everything above zero is white
        set_config(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h80, 1'b1);
        // a write beyond the register map changes nothing
        wait_idle();
        bus_write(ADDR_UNUSED, 8'h5A);
        send_pixel(8'h7F, 1'b1);
        send_pixel(8'h00, 1'b0);

        set_config(8'($urandom_range(40, 200)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        run_phase(PHASE_ITEMS, 1'b1);
        set_config(8'h00, 8'hFF, 8'h00);
        run_phase(PHASE_ITEMS, 1'b0);
        set_config(8'hFF, 8'h00, 8'hFF);
        run_phase(PHASE_ITEMS, 1'b0);
        idle_allowed = 1'b0;
        idle_on      = 1'b0;
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        run_phase(PHASE_ITEMS, 1'b0);
        wait_idle();

        $display("run covered %0d pixels with %0d frame starts under seven register settings",
                 items_sent, frames_sent);
        $display("%0d encoded bytes compared, %0d mismatches, %0d bytes never seen",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("binary_image_run_length_encoder_unit verification clean");
        end else begin
            $display("binary_image_run_length_encoder_unit verification failed");
        end
        $finish;
    end

endmodule
